// ----- rtl/core/gcr_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, widths and constants of the grid collision resolve unit.
// No dependencies; files other than gcr_checker refer to it by scoped names.
package gcr_pkg;

    localparam int POS_W   = 24;
    localparam int RAD_W   = 23;
    localparam int WX_W    = 26;
    localparam int VEL_W   = 25;
    localparam int DW      = 48;
    localparam int NUM_W   = 26;
    localparam int DEN_W   = 24;
    localparam int WIN_W   = 12;
    localparam int DD_W    = 29;
    localparam int SQ_W    = 58;
    localparam int BEST_W  = 59;

    localparam int DEF_MAX_ROWS    = 64;
    localparam int DEF_MAX_COLUMNS = 64;
    localparam int DEF_MAX_REACH   = 8;

    localparam logic [DD_W-1:0]   DIST_LIMIT2 = 29'd512000000;
    localparam logic [BEST_W-1:0] BEST_INIT   = 59'd262144000000000000;

    localparam logic OP_WRITE   = 1'b0;
    localparam logic OP_RESOLVE = 1'b1;

    typedef enum logic [2:0] {
        REG_AREA_X_MIN   = 3'd0,
        REG_AREA_X_MAX   = 3'd1,
        REG_AREA_Y_MIN   = 3'd2,
        REG_AREA_Y_MAX   = 3'd3,
        REG_CELL_WIDTH   = 3'd4,
        REG_CELL_HEIGHT  = 3'd5,
        REG_GRID_ROWS    = 3'd6,
        REG_GRID_COLUMNS = 3'd7
    } gcr_reg_t;

    typedef struct packed {
        logic signed [POS_W-1:0] x_min;
        logic signed [POS_W-1:0] x_max;
        logic signed [POS_W-1:0] y_min;
        logic signed [POS_W-1:0] y_max;
        logic [RAD_W-1:0]        cell_w;
        logic [RAD_W-1:0]        cell_h;
        logic [6:0]              rows;
        logic [6:0]              cols;
    } gcr_cfg_t;

    typedef struct packed {
        logic                    op;
        logic [5:0]              row;
        logic [5:0]              col;
        logic                    blocked;
        logic signed [WX_W-1:0]  x;
        logic signed [WX_W-1:0]  y;
        logic signed [POS_W-1:0] ox;
        logic signed [POS_W-1:0] oy;
        logic signed [VEL_W-1:0] vx;
        logic signed [VEL_W-1:0] vy;
        logic [RAD_W-1:0]        rad;
        logic                    upd;
    } gcr_item_t;

    function automatic logic signed [POS_W-1:0] sat24(input logic signed [DW-1:0] v);
        logic signed [POS_W-1:0] r;
        if (v > DW'(signed'(24'sh7FFFFF)))
            r = 24'sh7FFFFF;
        else if (v < DW'(signed'(24'sh800000)))
            r = 24'sh800000;
        else
            r = v[POS_W-1:0];
        return r;
    endfunction

endpackage

// ----- rtl/core/gcr_front.sv -----
`timescale 1ns / 1ps
// Front part: classifies incoming requests and applies the area walls.
// Depends on gcr_pkg.
module gcr_front
(
    input  gcr_pkg::gcr_cfg_t             cfg,
    input  logic                          operation,
    input  logic [5:0]                    cell_row,
    input  logic [5:0]                    cell_column,
    input  logic                          cell_blocked,
    input  logic signed [23:0]            proposed_x,
    input  logic signed [23:0]            proposed_y,
    input  logic signed [23:0]            previous_x,
    input  logic signed [23:0]            previous_y,
    input  logic signed [23:0]            velocity_x,
    input  logic signed [23:0]            velocity_y,
    input  logic [22:0]                   agent_radius,
    output gcr_pkg::gcr_item_t            item
);

    always_comb
    begin
        logic signed [26:0] x;
        logic signed [26:0] y;
        logic signed [26:0] r;
        logic signed [gcr_pkg::VEL_W-1:0] vx;
        logic signed [gcr_pkg::VEL_W-1:0] vy;
        logic upd;

        r   = signed'({4'b0000, agent_radius});
        x   = 27'(proposed_x);
        y   = 27'(proposed_y);
        vx  = 25'(velocity_x);
        vy  = 25'(velocity_y);
        upd = 1'b0;

        if (x + r > 27'(cfg.x_max))
        begin
            y   = 27'(previous_y);
            x   = 27'(cfg.x_max) - r;
            vx  = -vx;
            upd = 1'b1;
        end
        else if (x - r < 27'(cfg.x_min))
        begin
            y   = 27'(previous_y);
            x   = 27'(cfg.x_min) + r;
            vx  = -vx;
            upd = 1'b1;
        end

        if (y + r > 27'(cfg.y_max))
        begin
            y   = 27'(cfg.y_max) - r;
            vy  = -vy;
            upd = 1'b1;
        end
        else if (y - r < 27'(cfg.y_min))
        begin
            y   = 27'(cfg.y_min) + r;
            vy  = -vy;
            upd = 1'b1;
        end

        item.op      = operation;
        item.row     = cell_row;
        item.col     = cell_column;
        item.blocked = cell_blocked;
        item.x       = x[gcr_pkg::WX_W-1:0];
        item.y       = y[gcr_pkg::WX_W-1:0];
        item.ox      = previous_x;
        item.oy      = previous_y;
        item.vx      = vx;
        item.vy      = vy;
        item.rad     = agent_radius;
        item.upd     = upd;
    end

endmodule

// ----- rtl/core/gcr_queue.sv -----
`timescale 1ns / 1ps
// Two-entry request queue between the front and back parts.
// Depends on gcr_pkg.
module gcr_queue
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  gcr_pkg::gcr_item_t push_item,
    input  logic               pop,
    output gcr_pkg::gcr_item_t head,
    output logic               full,
    output logic               empty
);

    gcr_pkg::gcr_item_t entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;

    assign head  = entry_reg[rd_ptr_reg];
    assign full  = (cnt_reg == 2'd2);
    assign empty = (cnt_reg == 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !pop)
                cnt_reg <= cnt_reg + 2'd1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_item;
    end

endmodule

// ----- rtl/core/gcr_div.sv -----
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, shared by the back part.
// Depends on gcr_pkg for operand widths.
module gcr_div
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [gcr_pkg::NUM_W-1:0]   num,
    input  logic [gcr_pkg::DEN_W-1:0]   den,
    output logic                        done,
    output logic [gcr_pkg::NUM_W-1:0]   quotient
);

    localparam int NW = gcr_pkg::NUM_W;
    localparam int DNW = gcr_pkg::DEN_W;
    localparam int CW = $clog2(NW);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [NW-1:0] dvd_reg;
    logic [DNW-1:0] rem_reg;
    logic [DNW-1:0] den_reg;
    logic [DNW:0]   shifted;
    logic           ge;

    assign shifted  = {rem_reg, dvd_reg[NW-1]};
    assign ge       = (shifted >= {1'b0, den_reg});
    assign done     = done_reg;
    assign quotient = dvd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CW'(1);
                if (cnt_reg == CW'(NW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? DNW'(shifted - {1'b0, den_reg}) : shifted[DNW-1:0];
            dvd_reg <= {dvd_reg[NW-2:0], ge};
        end
    end

endmodule

// ----- rtl/core/gcr_back.sv -----
`timescale 1ns / 1ps
// Back part: grid memory, cell index and reach division, window scan,
// nearest obstacle and snap, output register. Depends on gcr_pkg, gcr_div.
module gcr_back
#(
    parameter int MAX_ROWS    = gcr_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLUMNS = gcr_pkg::DEF_MAX_COLUMNS,
    parameter int MAX_REACH   = gcr_pkg::DEF_MAX_REACH
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  gcr_pkg::gcr_cfg_t      cfg,
    input  logic                   q_empty,
    input  gcr_pkg::gcr_item_t     q_head,
    output logic                   q_pop,
    output logic                   clearing,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic signed [23:0]     result_x,
    output logic signed [23:0]     result_y,
    output logic signed [23:0]     result_velocity_x,
    output logic signed [23:0]     result_velocity_y,
    output logic                   adjusted,
    output logic                   hit_obstacle
);

    localparam int DEPTH = MAX_ROWS * MAX_COLUMNS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CIW   = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int RIW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int RW    = $clog2(MAX_REACH + 1);
    localparam int W     = gcr_pkg::WIN_W;
    localparam int DW    = gcr_pkg::DW;
    localparam int DRAIN_CYCLES = 3;

    typedef enum logic [12:0] {
        ST_CLEAR  = 13'b0000000000001,
        ST_IDLE   = 13'b0000000000010,
        ST_DIV_CI = 13'b0000000000100,
        ST_DIV_RI = 13'b0000000001000,
        ST_DIV_RX = 13'b0000000010000,
        ST_DIV_RY = 13'b0000000100000,
        ST_WINDOW = 13'b0000001000000,
        ST_SETUP  = 13'b0000010000000,
        ST_SCAN   = 13'b0000100000000,
        ST_DRAIN  = 13'b0001000000000,
        ST_EDGE   = 13'b0010000000000,
        ST_SNAP   = 13'b0100000000000,
        ST_OUT    = 13'b1000000000000
    } back_state_t;

    back_state_t state_reg, state_next;

    logic                mem [DEPTH];
    logic                mem_rd_reg;
    logic                mem_we;
    logic [AW-1:0]       mem_wa;
    logic                mem_wd;
    logic [AW-1:0]       rd_addr;
    logic [AW-1:0]       clr_reg;

    gcr_pkg::gcr_item_t  item_reg;
    logic                div_pend_reg;
    logic                div_start;
    logic                div_done;
    logic [gcr_pkg::NUM_W-1:0] div_num;
    logic [gcr_pkg::DEN_W-1:0] div_den;
    logic [gcr_pkg::NUM_W-1:0] div_q;

    logic [gcr_pkg::RAD_W-1:0] cw;
    logic [gcr_pkg::RAD_W-1:0] ch;
    logic [W-1:0]        cols_w;
    logic [W-1:0]        rows_w;
    logic signed [26:0]  dx_full;
    logic signed [26:0]  dy_full;

    logic [W-1:0]        ci_reg;
    logic [W-1:0]        ri_reg;
    logic [RW-1:0]       rx_reg;
    logic [RW-1:0]       ry_reg;
    logic [CIW-1:0]      x0_reg;
    logic [CIW-1:0]      x1_reg;
    logic [RIW-1:0]      y0_reg;
    logic [RIW-1:0]      y1_reg;
    logic [CIW-1:0]      i_reg;
    logic [RIW-1:0]      j_reg;
    logic signed [DW-1:0] cx2_reg;
    logic signed [DW-1:0] cx2_row0_reg;
    logic signed [DW-1:0] cy2_reg;

    logic                s1_valid_reg;
    logic                s1_near_reg;
    logic [gcr_pkg::DD_W-1:0] s1_ddx_reg;
    logic [gcr_pkg::DD_W-1:0] s1_ddy_reg;
    logic signed [DW-1:0] s1_cx2_reg;
    logic signed [DW-1:0] s1_cy2_reg;
    logic                s2_valid_reg;
    logic [gcr_pkg::SQ_W-1:0] s2_sqx_reg;
    logic [gcr_pkg::SQ_W-1:0] s2_sqy_reg;
    logic signed [DW-1:0] s2_cx2_reg;
    logic signed [DW-1:0] s2_cy2_reg;
    logic [gcr_pkg::BEST_W-1:0] best_reg;
    logic [gcr_pkg::BEST_W-1:0] sq_sum;
    logic signed [DW-1:0] best_cx2_reg;
    logic signed [DW-1:0] best_cy2_reg;
    logic                found_reg;
    logic [1:0]          drain_reg;

    logic signed [DW-1:0] ex_hi_reg;
    logic signed [DW-1:0] ex_lo_reg;
    logic signed [DW-1:0] ey_hi_reg;
    logic signed [DW-1:0] ey_lo_reg;
    logic signed [DW-1:0] fin_x_reg;
    logic signed [DW-1:0] fin_y_reg;
    logic signed [gcr_pkg::VEL_W-1:0] fin_vx_reg;
    logic signed [gcr_pkg::VEL_W-1:0] fin_vy_reg;
    logic                fin_upd_reg;
    logic                fin_hit_reg;

    logic                out_valid_reg;
    logic signed [23:0]  out_x_reg;
    logic signed [23:0]  out_y_reg;
    logic signed [23:0]  out_vx_reg;
    logic signed [23:0]  out_vy_reg;
    logic                out_upd_reg;
    logic                out_hit_reg;
    logic                out_load;

    logic [W-1:0]        lo_x, hi_x, lo_y, hi_y, sum_x, sum_y;
    logic [gcr_pkg::RAD_W+CIW-1:0] mul_x;
    logic [gcr_pkg::RAD_W+RIW-1:0] mul_y;
    logic signed [DW-1:0] cx2_start;
    logic signed [DW-1:0] cy2_start;
    logic signed [DW-1:0] diff_x, diff_y, abs_x, abs_y;
    logic                 last_col, last_row;
    logic                 write_ok;

    // configuration in effect
    assign cw = (cfg.cell_w == '0) ? gcr_pkg::RAD_W'(1) : cfg.cell_w;
    assign ch = (cfg.cell_h == '0) ? gcr_pkg::RAD_W'(1) : cfg.cell_h;

    always_comb
    begin
        if (cfg.cols == 7'd0)
            cols_w = W'(1);
        else if (W'(cfg.cols) > W'(MAX_COLUMNS))
            cols_w = W'(MAX_COLUMNS);
        else
            cols_w = W'(cfg.cols);
        if (cfg.rows == 7'd0)
            rows_w = W'(1);
        else if (W'(cfg.rows) > W'(MAX_ROWS))
            rows_w = W'(MAX_ROWS);
        else
            rows_w = W'(cfg.rows);
    end

    assign dx_full = 27'(item_reg.x) - 27'(cfg.x_min);
    assign dy_full = 27'(item_reg.y) - 27'(cfg.y_min);

    // divider operands
    always_comb
    begin
        div_num = '0;
        div_den = '0;
        case (state_reg)
            ST_DIV_CI:
            begin
                div_num = dx_full[26] ? '0 : dx_full[gcr_pkg::NUM_W-1:0];
                div_den = gcr_pkg::DEN_W'(cw);
            end
            ST_DIV_RI:
            begin
                div_num = dy_full[26] ? '0 : dy_full[gcr_pkg::NUM_W-1:0];
                div_den = gcr_pkg::DEN_W'(ch);
            end
            ST_DIV_RX:
            begin
                div_num = gcr_pkg::NUM_W'({cw, 1'b0}) + gcr_pkg::NUM_W'(item_reg.rad);
                div_den = {item_reg.rad, 1'b0};
            end
            ST_DIV_RY:
            begin
                div_num = gcr_pkg::NUM_W'({ch, 1'b0}) + gcr_pkg::NUM_W'(item_reg.rad);
                div_den = {item_reg.rad, 1'b0};
            end
            default:
            begin
                div_num = '0;
                div_den = '0;
            end
        endcase
    end

    assign div_start = ((state_reg == ST_DIV_CI) || (state_reg == ST_DIV_RI) ||
                        (state_reg == ST_DIV_RX) || (state_reg == ST_DIV_RY)) &&
                       !div_pend_reg;

    gcr_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .num      (div_num),
        .den      (div_den),
        .done     (div_done),
        .quotient (div_q)
    );

    // window bounds
    assign sum_x = ci_reg + W'(rx_reg);
    assign sum_y = ri_reg + W'(ry_reg);
    assign lo_x  = (ci_reg >= W'(rx_reg)) ? ci_reg - W'(rx_reg) : '0;
    assign lo_y  = (ri_reg >= W'(ry_reg)) ? ri_reg - W'(ry_reg) : '0;
    assign hi_x  = (sum_x >= cols_w) ? cols_w - W'(1) : sum_x;
    assign hi_y  = (sum_y >= rows_w) ? rows_w - W'(1) : sum_y;

    // first cell centres of the window, doubled
    assign mul_x = cw * x0_reg;
    assign mul_y = ch * y0_reg;
    assign cx2_start = (DW'(cfg.x_min) <<< 1) + DW'(cw) + (DW'(mul_x) <<< 1);
    assign cy2_start = (DW'(cfg.y_min) <<< 1) + DW'(ch) + (DW'(mul_y) <<< 1);

    // scan
    assign last_col = (i_reg == x1_reg);
    assign last_row = (j_reg == y1_reg);
    assign rd_addr  = AW'(32'(j_reg) * MAX_COLUMNS + 32'(i_reg));
    assign diff_x   = (DW'(item_reg.x) <<< 1) - cx2_reg;
    assign diff_y   = (DW'(item_reg.y) <<< 1) - cy2_reg;
    assign abs_x    = (diff_x < 0) ? -diff_x : diff_x;
    assign abs_y    = (diff_y < 0) ? -diff_y : diff_y;
    assign sq_sum   = gcr_pkg::BEST_W'(s2_sqx_reg) + gcr_pkg::BEST_W'(s2_sqy_reg);

    // grid memory port
    assign q_pop    = (state_reg == ST_IDLE) && !q_empty;
    assign write_ok = (32'(q_head.row) < MAX_ROWS) && (32'(q_head.col) < MAX_COLUMNS);
    assign mem_we   = (state_reg == ST_CLEAR) ||
                      (q_pop && (q_head.op == gcr_pkg::OP_WRITE) && write_ok);
    assign mem_wa   = (state_reg == ST_CLEAR) ? clr_reg :
                      AW'(32'(q_head.row) * MAX_COLUMNS + 32'(q_head.col));
    assign mem_wd   = (state_reg == ST_CLEAR) ? 1'b0 : q_head.blocked;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        mem_rd_reg <= mem[rd_addr];
    end

    assign out_load = (state_reg == ST_OUT) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
                if (clr_reg == AW'(DEPTH - 1))
                    state_next = ST_IDLE;
            ST_IDLE:
                if (q_pop && (q_head.op == gcr_pkg::OP_RESOLVE))
                    state_next = ST_DIV_CI;
            ST_DIV_CI:
                if (div_done)
                    state_next = ST_DIV_RI;
            ST_DIV_RI:
                if (div_done)
                    state_next = ST_DIV_RX;
            ST_DIV_RX:
                if (div_done)
                    state_next = ST_DIV_RY;
            ST_DIV_RY:
                if (div_done)
                    state_next = ST_WINDOW;
            ST_WINDOW:
                state_next = ST_SETUP;
            ST_SETUP:
                state_next = ST_SCAN;
            ST_SCAN:
                if (last_col && last_row)
                    state_next = ST_DRAIN;
            ST_DRAIN:
                if (drain_reg == 2'(DRAIN_CYCLES - 1))
                    state_next = ST_EDGE;
            ST_EDGE:
                state_next = ST_SNAP;
            ST_SNAP:
                state_next = ST_OUT;
            ST_OUT:
                if (out_load)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            div_pend_reg  <= 1'b0;
            drain_reg     <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
                clr_reg <= clr_reg + AW'(1);
            if (div_start)
                div_pend_reg <= 1'b1;
            else if (div_done)
                div_pend_reg <= 1'b0;
            if (state_reg == ST_DRAIN)
                drain_reg <= drain_reg + 2'd1;
            else
                drain_reg <= '0;
            s1_valid_reg <= (state_reg == ST_SCAN);
            s2_valid_reg <= s1_valid_reg && mem_rd_reg && s1_near_reg;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        logic signed [DW-1:0] x2, y2, o2x, o2y, fx, fy;
        logic signed [gcr_pkg::VEL_W-1:0] fvx, fvy;
        logic fupd, fhit;

        x2   = DW'(item_reg.x) <<< 1;
        y2   = DW'(item_reg.y) <<< 1;
        o2x  = DW'(item_reg.ox) <<< 1;
        o2y  = DW'(item_reg.oy) <<< 1;
        fx   = DW'(item_reg.x);
        fy   = DW'(item_reg.y);
        fvx  = item_reg.vx;
        fvy  = item_reg.vy;
        fupd = item_reg.upd;
        fhit = 1'b0;

        if (q_pop)
            item_reg <= q_head;

        if (div_done)
        begin
            case (state_reg)
                ST_DIV_CI:
                    ci_reg <= (div_q >= gcr_pkg::NUM_W'(cols_w)) ? cols_w - W'(1) : W'(div_q);
                ST_DIV_RI:
                    ri_reg <= (div_q >= gcr_pkg::NUM_W'(rows_w)) ? rows_w - W'(1) : W'(div_q);
                ST_DIV_RX:
                    rx_reg <= (div_q >= gcr_pkg::NUM_W'(MAX_REACH)) ? RW'(MAX_REACH) :
                              RW'(div_q) + RW'(1);
                ST_DIV_RY:
                    ry_reg <= (div_q >= gcr_pkg::NUM_W'(MAX_REACH)) ? RW'(MAX_REACH) :
                              RW'(div_q) + RW'(1);
                default:
                    ci_reg <= ci_reg;
            endcase
        end

        if (state_reg == ST_WINDOW)
        begin
            x0_reg <= CIW'(lo_x);
            x1_reg <= CIW'(hi_x);
            y0_reg <= RIW'(lo_y);
            y1_reg <= RIW'(hi_y);
        end

        if (state_reg == ST_SETUP)
        begin
            i_reg        <= x0_reg;
            j_reg        <= y0_reg;
            cx2_reg      <= cx2_start;
            cx2_row0_reg <= cx2_start;
            cy2_reg      <= cy2_start;
            best_reg     <= gcr_pkg::BEST_INIT;
            found_reg    <= 1'b0;
        end
        else if (state_reg == ST_SCAN)
        begin
            if (last_col)
            begin
                i_reg   <= x0_reg;
                j_reg   <= j_reg + RIW'(1);
                cx2_reg <= cx2_row0_reg;
                cy2_reg <= cy2_reg + DW'({ch, 1'b0});
            end
            else
            begin
                i_reg   <= i_reg + CIW'(1);
                cx2_reg <= cx2_reg + DW'({cw, 1'b0});
            end
        end

        s1_near_reg <= (abs_x < DW'(gcr_pkg::DIST_LIMIT2)) &&
                       (abs_y < DW'(gcr_pkg::DIST_LIMIT2));
        s1_ddx_reg  <= abs_x[gcr_pkg::DD_W-1:0];
        s1_ddy_reg  <= abs_y[gcr_pkg::DD_W-1:0];
        s1_cx2_reg  <= cx2_reg;
        s1_cy2_reg  <= cy2_reg;

        s2_sqx_reg  <= gcr_pkg::SQ_W'(s1_ddx_reg) * gcr_pkg::SQ_W'(s1_ddx_reg);
        s2_sqy_reg  <= gcr_pkg::SQ_W'(s1_ddy_reg) * gcr_pkg::SQ_W'(s1_ddy_reg);
        s2_cx2_reg  <= s1_cx2_reg;
        s2_cy2_reg  <= s1_cy2_reg;

        if (s2_valid_reg && (sq_sum < best_reg) && (state_reg != ST_SETUP))
        begin
            best_reg     <= sq_sum;
            best_cx2_reg <= s2_cx2_reg;
            best_cy2_reg <= s2_cy2_reg;
            found_reg    <= 1'b1;
        end

        if (state_reg == ST_EDGE)
        begin
            ex_hi_reg <= best_cx2_reg + DW'(cw) + (DW'(item_reg.rad) <<< 1);
            ex_lo_reg <= best_cx2_reg - DW'(cw) - (DW'(item_reg.rad) <<< 1);
            ey_hi_reg <= best_cy2_reg + DW'(ch) + (DW'(item_reg.rad) <<< 1);
            ey_lo_reg <= best_cy2_reg - DW'(ch) - (DW'(item_reg.rad) <<< 1);
        end

        if (state_reg == ST_SNAP)
        begin
            if (found_reg && (x2 < ex_hi_reg) && (x2 > ex_lo_reg) &&
                (y2 < ey_hi_reg) && (y2 > ey_lo_reg))
            begin
                fx   = DW'(item_reg.ox);
                fy   = DW'(item_reg.oy);
                fupd = 1'b1;
                fhit = 1'b1;
                if ((o2x > ex_lo_reg) && (o2x < ex_hi_reg))
                begin
                    fvx = -item_reg.vx;
                    fx  = ((ex_hi_reg + ex_lo_reg) < (o2x <<< 1)) ?
                          ((ex_hi_reg + DW'(1)) >>> 1) : (ex_lo_reg >>> 1);
                end
                if ((o2y > ey_lo_reg) && (o2y < ey_hi_reg))
                begin
                    fvy = -item_reg.vy;
                    fy  = ((ey_hi_reg + ey_lo_reg) < (o2y <<< 1)) ?
                          ((ey_hi_reg + DW'(1)) >>> 1) : (ey_lo_reg >>> 1);
                end
            end
            fin_x_reg   <= fx;
            fin_y_reg   <= fy;
            fin_vx_reg  <= fvx;
            fin_vy_reg  <= fvy;
            fin_upd_reg <= fupd;
            fin_hit_reg <= fhit;
        end

        if (out_load)
        begin
            out_x_reg   <= gcr_pkg::sat24(fin_x_reg);
            out_y_reg   <= gcr_pkg::sat24(fin_y_reg);
            out_vx_reg  <= gcr_pkg::sat24(DW'(fin_vx_reg));
            out_vy_reg  <= gcr_pkg::sat24(DW'(fin_vy_reg));
            out_upd_reg <= fin_upd_reg;
            out_hit_reg <= fin_hit_reg;
        end
    end

    assign clearing          = (state_reg == ST_CLEAR);
    assign out_valid         = out_valid_reg;
    assign result_x          = out_x_reg;
    assign result_y          = out_y_reg;
    assign result_velocity_x = out_vx_reg;
    assign result_velocity_y = out_vy_reg;
    assign adjusted          = out_upd_reg;
    assign hit_obstacle      = out_hit_reg;

endmodule

// ----- rtl/core/grid_collision_resolve_unit.sv -----
`timescale 1ns / 1ps
// Top level of the grid collision resolve unit: configuration registers,
// front part, request queue and back part. Depends on gcr_pkg, gcr_front,
// gcr_queue and gcr_back.
// Usage:
//   Requests enter on in_valid / in_stall. operation 0 writes one grid cell
//   and gives no result; operation 1 resolves one agent and gives exactly
//   one result on out_valid / out_stall. A transfer happens on a rising edge
//   with valid high and stall low.
//   Configuration is written through cfg_we, cfg_index and cfg_data, one
//   register per edge; the user must do so only while no request is in flight.
// Processing:
//   A cell write reaches the grid in the cycle after it is taken when the back
//   part is idle. A resolve runs four divisions in the shared one-bit-per-cycle
//   divider (cell index and reach on both axes), a setup step, the window scan,
//   one grid cell per cycle through the memory read port, then pipeline drain,
//   snap and output load. Requests are worked on one at a time; the two-entry
//   queue takes further requests meanwhile.
// Reset:
//   After reset the grid memory is cleared, one cell per cycle over all
//   MAX_ROWS * MAX_COLUMNS cells (4096 by default), with in_stall high.
// Output stall:
//   A result waits in the output register; the back part holds it and the
//   queue fills until in_stall rises.
module grid_collision_resolve_unit
#(
    parameter int MAX_ROWS    = gcr_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLUMNS = gcr_pkg::DEF_MAX_COLUMNS,
    parameter int MAX_REACH   = gcr_pkg::DEF_MAX_REACH
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [23:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               operation,
    input  logic [5:0]         cell_row,
    input  logic [5:0]         cell_column,
    input  logic               cell_blocked,
    input  logic signed [23:0] proposed_x,
    input  logic signed [23:0] proposed_y,
    input  logic signed [23:0] previous_x,
    input  logic signed [23:0] previous_y,
    input  logic signed [23:0] velocity_x,
    input  logic signed [23:0] velocity_y,
    input  logic [22:0]        agent_radius,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [23:0] result_x,
    output logic signed [23:0] result_y,
    output logic signed [23:0] result_velocity_x,
    output logic signed [23:0] result_velocity_y,
    output logic               adjusted,
    output logic               hit_obstacle
);

    gcr_pkg::gcr_cfg_t  cfg_reg;
    gcr_pkg::gcr_item_t front_item;
    gcr_pkg::gcr_item_t q_head;
    logic               q_full;
    logic               q_empty;
    logic               q_pop;
    logic               clearing;
    logic               push;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.x_min  <= 24'sd0;
            cfg_reg.x_max  <= 24'sd131072;
            cfg_reg.y_min  <= 24'sd0;
            cfg_reg.y_max  <= 24'sd131072;
            cfg_reg.cell_w <= 23'd2048;
            cfg_reg.cell_h <= 23'd2048;
            cfg_reg.rows   <= 7'd64;
            cfg_reg.cols   <= 7'd64;
        end
        else if (cfg_we)
        begin
            case (gcr_pkg::gcr_reg_t'(cfg_index))
                gcr_pkg::REG_AREA_X_MIN:   cfg_reg.x_min  <= cfg_data;
                gcr_pkg::REG_AREA_X_MAX:   cfg_reg.x_max  <= cfg_data;
                gcr_pkg::REG_AREA_Y_MIN:   cfg_reg.y_min  <= cfg_data;
                gcr_pkg::REG_AREA_Y_MAX:   cfg_reg.y_max  <= cfg_data;
                gcr_pkg::REG_CELL_WIDTH:   cfg_reg.cell_w <= cfg_data[22:0];
                gcr_pkg::REG_CELL_HEIGHT:  cfg_reg.cell_h <= cfg_data[22:0];
                gcr_pkg::REG_GRID_ROWS:    cfg_reg.rows   <= cfg_data[6:0];
                gcr_pkg::REG_GRID_COLUMNS: cfg_reg.cols   <= cfg_data[6:0];
                default:                   cfg_reg        <= cfg_reg;
            endcase
        end
    end

    assign in_stall = q_full || clearing;
    assign push     = in_valid && !in_stall;

    gcr_front u_front
    (
        .cfg          (cfg_reg),
        .operation    (operation),
        .cell_row     (cell_row),
        .cell_column  (cell_column),
        .cell_blocked (cell_blocked),
        .proposed_x   (proposed_x),
        .proposed_y   (proposed_y),
        .previous_x   (previous_x),
        .previous_y   (previous_y),
        .velocity_x   (velocity_x),
        .velocity_y   (velocity_y),
        .agent_radius (agent_radius),
        .item         (front_item)
    );

    gcr_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (front_item),
        .pop       (q_pop),
        .head      (q_head),
        .full      (q_full),
        .empty     (q_empty)
    );

    gcr_back
    #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_REACH   (MAX_REACH)
    )
    u_back
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg               (cfg_reg),
        .q_empty           (q_empty),
        .q_head            (q_head),
        .q_pop             (q_pop),
        .clearing          (clearing),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .result_x          (result_x),
        .result_y          (result_y),
        .result_velocity_x (result_velocity_x),
        .result_velocity_y (result_velocity_y),
        .adjusted          (adjusted),
        .hit_obstacle      (hit_obstacle)
    );

endmodule

// ----- rtl/core/gcr_checker.sv -----
`timescale 1ns / 1ps
// Port-level checker of the grid collision resolve unit and its bind.
// Depends on grid_collision_resolve_unit.
module gcr_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [23:0] result_x,
    input logic               adjusted,
    input logic               hit_obstacle
);

    a_clear_after_reset: assert property (@(posedge clk)
        (rst_n && !$past(rst_n)) |-> in_stall)
        else $error("requests taken while the grid is cleared");

    a_hit_adjusts: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && hit_obstacle) |-> adjusted)
        else $error("obstacle hit without position change");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(result_x) &&
                                      $stable(hit_obstacle)))
        else $error("stalled result changed");

endmodule

bind grid_collision_resolve_unit gcr_checker u_gcr_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .result_x     (result_x),
    .adjusted     (adjusted),
    .hit_obstacle (hit_obstacle)
);
